// ===== rtl/core/pcbd_pkg.sv =====
package pcbd_pkg;

  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned LEVEL_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_BOOT    = 3'd5;

  localparam logic [TIMER_W-1:0] RST_FIRST_ENABLE = 16'd25000;
  localparam logic [TIMER_W-1:0] RST_ENABLE       = 16'd300;
  localparam logic [TIMER_W-1:0] RST_PULSE_LOW    = 16'd1;
  localparam logic [TIMER_W-1:0] RST_PULSE_HIGH   = 16'd300;
  localparam logic [TIMER_W-1:0] RST_DISABLE_HOLD = 16'd250;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HOLD   = 3'd1,
    PH_ENABLE = 3'd2,
    PH_LOW    = 3'd3,
    PH_HIGH   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TIMER_W-1:0] first_enable_ticks;
    logic [TIMER_W-1:0] enable_ticks;
    logic [TIMER_W-1:0] pulse_low_ticks;
    logic [TIMER_W-1:0] pulse_high_ticks;
    logic [TIMER_W-1:0] disable_hold_ticks;
    logic               cold_boot;
  } cfg_t;

  typedef struct packed {
    logic               pin;
    logic               busy_res;
    logic               rejected;
    logic [LEVEL_W-1:0] pulses_left;
  } res_t;

  // a zero duration still lasts one tick
  function automatic logic [TIMER_W-1:0] load_ticks(input logic [TIMER_W-1:0] t);
    load_ticks = (t == '0) ? TIMER_W'(1) : t;
  endfunction

endpackage

// ===== rtl/core/pcbd_cfg.sv =====
module pcbd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcbd_pkg::CFG_DAT_W-1:0] cfg_data,
  output pcbd_pkg::cfg_t                cfg
);

  pcbd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_enable_ticks <= pcbd_pkg::RST_FIRST_ENABLE;
      cfg_r.enable_ticks       <= pcbd_pkg::RST_ENABLE;
      cfg_r.pulse_low_ticks    <= pcbd_pkg::RST_PULSE_LOW;
      cfg_r.pulse_high_ticks   <= pcbd_pkg::RST_PULSE_HIGH;
      cfg_r.disable_hold_ticks <= pcbd_pkg::RST_DISABLE_HOLD;
      cfg_r.cold_boot          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcbd_pkg::CFG_FIRST_ENABLE: cfg_r.first_enable_ticks <= cfg_data;
        pcbd_pkg::CFG_ENABLE:       cfg_r.enable_ticks       <= cfg_data;
        pcbd_pkg::CFG_PULSE_LOW:    cfg_r.pulse_low_ticks    <= cfg_data;
        pcbd_pkg::CFG_PULSE_HIGH:   cfg_r.pulse_high_ticks   <= cfg_data;
        pcbd_pkg::CFG_DISABLE_HOLD: cfg_r.disable_hold_ticks <= cfg_data;
        pcbd_pkg::CFG_COLD_BOOT:    cfg_r.cold_boot          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pcbd_fsm.sv =====
module pcbd_fsm #(
  parameter int unsigned LEVELS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         operation,
  input  logic [pcbd_pkg::LEVEL_W-1:0] level,
  input  logic                         panel_on,
  input  pcbd_pkg::cfg_t               cfg,
  output pcbd_pkg::res_t               res
);

  localparam int unsigned LW = $clog2(LEVELS + 1);
  localparam int unsigned CW = $clog2(LEVELS);
  localparam logic [LW-1:0] LEV_MAX = LW'(LEVELS);

  logic [LW-1:0]                prev_r, prev_nxt;
  logic                         init_r, init_nxt;
  logic                         seen_r, seen_nxt;
  pcbd_pkg::phase_t             phase_r, phase_nxt;
  logic [pcbd_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         pin_r, pin_nxt;

  logic [LW-1:0] prev_eff, lvl_sat;
  logic          init_eff;
  logic [LW:0]   count_w;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_src;
  logic          do_pulse;
  logic          rej;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= LEV_MAX;
      init_r  <= 1'b0;
      seen_r  <= 1'b0;
      phase_r <= pcbd_pkg::PH_IDLE;
      timer_r <= '0;
      cnt_r   <= '0;
      pin_r   <= 1'b0;
    end else if (step) begin
      prev_r  <= prev_nxt;
      init_r  <= init_nxt;
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      cnt_r   <= cnt_nxt;
      pin_r   <= pin_nxt;
    end
  end

  always_comb begin
    // first set request after reset may re-base previous level on cold boot
    prev_eff = prev_r;
    init_eff = init_r;
    if (!seen_r && cfg.cold_boot) begin
      prev_eff = '0;
      init_eff = 1'b1;
    end
    if ({1'b0, level} > (pcbd_pkg::LEVEL_W + 1)'(LEVELS)) lvl_sat = LEV_MAX;
    else lvl_sat = LW'(level);

    if (prev_eff < lvl_sat) count_w = {1'b0, LEV_MAX} - {1'b0, lvl_sat} + {1'b0, prev_eff};
    else count_w = {1'b0, prev_eff} - {1'b0, lvl_sat};
    count = count_w[CW-1:0];
  end

  always_comb begin
    prev_nxt  = prev_r;
    init_nxt  = init_r;
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    cnt_nxt   = cnt_r;
    pin_nxt   = pin_r;
    rej       = 1'b0;
    do_pulse  = 1'b0;
    cnt_src   = cnt_r;

    if (operation == pcbd_pkg::OP_TICK) begin
      if (phase_r != pcbd_pkg::PH_IDLE) begin
        if (timer_r > pcbd_pkg::TIMER_W'(1)) begin
          timer_nxt = timer_r - pcbd_pkg::TIMER_W'(1);
        end else begin
          timer_nxt = '0;
          case (phase_r)
            pcbd_pkg::PH_HOLD: phase_nxt = pcbd_pkg::PH_IDLE;
            pcbd_pkg::PH_LOW: begin
              pin_nxt   = 1'b1;
              phase_nxt = pcbd_pkg::PH_HIGH;
              timer_nxt = pcbd_pkg::load_ticks(cfg.pulse_high_ticks);
            end
            pcbd_pkg::PH_ENABLE,
            pcbd_pkg::PH_HIGH: do_pulse = 1'b1;
            default: phase_nxt = pcbd_pkg::PH_IDLE;
          endcase
        end
      end
    end else if (phase_r != pcbd_pkg::PH_IDLE) begin
      rej = 1'b1;
    end else begin
      seen_nxt = 1'b1;
      prev_nxt = prev_eff;
      init_nxt = init_eff;
      if (lvl_sat != prev_eff && panel_on) begin
        prev_nxt = lvl_sat;
        if (lvl_sat == '0) begin
          pin_nxt   = 1'b0;
          phase_nxt = pcbd_pkg::PH_HOLD;
          timer_nxt = pcbd_pkg::load_ticks(cfg.disable_hold_ticks);
          cnt_nxt   = '0;
        end else if (prev_eff == '0) begin
          cnt_nxt   = count;
          pin_nxt   = 1'b1;
          phase_nxt = pcbd_pkg::PH_ENABLE;
          if (init_eff) begin
            init_nxt  = 1'b0;
            timer_nxt = pcbd_pkg::load_ticks(cfg.first_enable_ticks);
          end else begin
            timer_nxt = pcbd_pkg::load_ticks(cfg.enable_ticks);
          end
        end else begin
          cnt_src  = count;
          do_pulse = 1'b1;
        end
      end
    end

    // start next step pulse, or finish the train with the pin high
    if (do_pulse) begin
      if (cnt_src != '0) begin
        cnt_nxt   = cnt_src - CW'(1);
        pin_nxt   = 1'b0;
        phase_nxt = pcbd_pkg::PH_LOW;
        timer_nxt = pcbd_pkg::load_ticks(cfg.pulse_low_ticks);
      end else begin
        cnt_nxt   = '0;
        pin_nxt   = 1'b1;
        phase_nxt = pcbd_pkg::PH_IDLE;
        timer_nxt = '0;
      end
    end

    res.pin         = pin_nxt;
    res.busy_res    = (phase_nxt != pcbd_pkg::PH_IDLE);
    res.rejected    = rej;
    res.pulses_left = pcbd_pkg::LEVEL_W'(cnt_nxt);
  end

endmodule

// ===== rtl/core/pcbd_outq.sv =====
module pcbd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcbd_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output pcbd_pkg::res_t out_data
);

  pcbd_pkg::res_t mem_r [2];
  logic [1:0]     count_r, count_nxt;
  logic           wr_r, rd_r;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/core/pulse_count_backlight_dimmer_core.sv =====
// Each request updates all state in one pass; its result enters the result queue on acceptance.
// Throughput: one tick or set-level request per cycle while the result queue is not full.
// A two-entry result queue lets requests keep coming while one result waits; a third stalls.
// Reset (rst_n low, synchronous): registers to defaults, level state to maximum, queue empty.
module pulse_count_backlight_dimmer_core #(
  parameter int unsigned LEVELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pcbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcbd_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [pcbd_pkg::LEVEL_W-1:0]   in_level,
  input  logic                           in_panel_on,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_pin,
  output logic                           out_busy_res,
  output logic                           out_rejected,
  output logic [pcbd_pkg::LEVEL_W-1:0]   out_pulses_left
);

  pcbd_pkg::cfg_t cfg;
  pcbd_pkg::res_t res, q_data;
  logic           q_full, step;

  assign in_ready = !q_full;
  assign step     = in_valid && in_ready;

  pcbd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pcbd_fsm #(.LEVELS(LEVELS)) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .operation(in_operation),
    .level    (in_level),
    .panel_on (in_panel_on),
    .cfg      (cfg),
    .res      (res)
  );

  pcbd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .push_data(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (q_data)
  );

  assign out_pin         = q_data.pin;
  assign out_busy_res    = q_data.busy_res;
  assign out_rejected    = q_data.rejected;
  assign out_pulses_left = q_data.pulses_left;

endmodule

// ===== rtl/core/pcbd_checker.sv =====
module pcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_pin,
  input logic       out_busy_res,
  input logic       out_rejected,
  input logic [4:0] out_pulses_left
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin) && $stable(out_busy_res)
      && $stable(out_rejected) && $stable(out_pulses_left))
    else $error("result changed while stalled");

  // a rejected request leaves the sequence running
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("rejected request without busy");

  a_pulses_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pulses_left != 5'd0) |-> out_busy_res)
    else $error("pulses pending while idle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

endmodule

bind pulse_count_backlight_dimmer_core pcbd_checker u_pcbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pin        (out_pin),
  .out_busy_res   (out_busy_res),
  .out_rejected   (out_rejected),
  .out_pulses_left(out_pulses_left)
);
